// ----- src/egcd_pkg.sv -----
// ============================================================================
// egcd_pkg: shared constants and types for the extended gcd block
// Holds the default operand width and the control bundle passed from the
// serial divider to the sequencer.
// ============================================================================
package egcd_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  // start strobe, busy flag and done flag of the bit-serial divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ----- src/egcd_div.sv -----
// ============================================================================
// egcd_div: bit-serial restoring divider
// Shifts the dividend in one bit per cycle and develops one quotient bit per
// cycle; raises done together with the last quotient bit of each division.
// ============================================================================
module egcd_div
  import egcd_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output div_ctl_t     ctl,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // one restoring step per cycle while busy
  always_comb begin
    trial    = {rem_r, q_r[W-1]};
    diff     = trial - {1'b0, d_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// ----- src/egcd_mac.sv -----
// ============================================================================
// egcd_mac: bit-serial coefficient update
// Forms nx = y - x*q by shift-and-add, one quotient bit per cycle, MSB first.
// ============================================================================
module egcd_mac
  import egcd_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W:0]   x_in,
  input  logic [W:0]   y_in,
  input  logic [W-1:0] q_in,
  output logic         done,
  output logic [W:0]   result
);

  localparam int CW = $clog2(W + 1);

  logic [W:0]    acc_r, acc_nxt;
  logic [W:0]    x_r, x_nxt;
  logic [W:0]    y_r, y_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  // Horner accumulation of x*q modulo 2^(W+1)
  always_comb begin
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      x_nxt    = x_in;
      y_nxt    = y_in;
      q_nxt    = q_in;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {acc_r[W-1:0], 1'b0} + (q_r[W-1] ? x_r : '0);
      q_nxt   = {q_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    q_r   <= q_nxt;
  end

  assign done   = done_r;
  assign result = y_r - acc_r;

endmodule

// ----- src/extended_gcd_bezout.sv -----
// Each Euclid round runs the serial divider on the forward pass, and each
// stored quotient runs the serial coefficient update on the backward pass;
// a zero operand gives its result word in the cycle after acceptance.
// Throughput: one item at a time; the next word is taken once the sequencer is
// idle and the result register is free. The quotient stack has one write port and one registered read port.
// Reset: synchronous active-low rst_n clears the sequencer and output valid.
// ============================================================================
// extended_gcd_bezout: gcd and Bezout coefficients of two signed operands
// Sequencer around a bit-serial divider and a bit-serial multiply-subtract,
// with the quotients of the forward pass kept in a stack memory.
// ============================================================================
module extended_gcd_bezout
  import egcd_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // operand_a [W-1:0], operand_b [2W-1:W], zero fill
  input  logic [(2*DATA_WIDTH+7)/8*8-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // divisor [W-1:0], coef_a [2W:W], coef_b [3W+1:2W+1], zero fill
  output logic [(3*DATA_WIDTH+2+7)/8*8-1:0] out_tdata,
  // undefined
  output logic                      out_tuser
);

  localparam int W    = DATA_WIDTH;
  localparam int IW   = (2*W+7)/8*8;
  localparam int OW   = (3*W+2+7)/8*8;
  localparam int SD   = 2*W;
  localparam int SAW  = $clog2(SD + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_DWT  = 3'd2;
  localparam logic [2:0] ST_POP  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_MAC  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]     st_r, st_nxt;
  logic [W-1:0]   u_r, u_nxt, v_r, v_nxt;
  logic [W:0]     x_r, x_nxt, y_r, y_nxt;
  logic           swap_r, swap_nxt, na_r, na_nxt, nb_r, nb_nxt;
  logic [SAW-1:0] sp_r, sp_nxt;
  logic           ov_r, ov_nxt;
  logic [OW-1:0]  od_r, od_nxt;
  logic           ou_r, ou_nxt;
  logic           div_go, mac_go, push;
  div_ctl_t       dctl;
  logic [W-1:0]   dq, dr, qrd_r;
  logic           mdone;
  logic [W:0]     mres;
  logic [W-1:0]   qmem [SD];
  logic [W-1:0]   ra, rb, ma, mb;
  logic [W:0]     ca, cb;

  egcd_div #(.W(W)) u_div (
    .clk, .rst_n, .start(div_go), .dividend(v_r), .divisor(u_r),
    .ctl(dctl), .quotient(dq), .remainder(dr)
  );

  egcd_mac #(.W(W)) u_mac (
    .clk, .rst_n, .start(mac_go), .x_in(x_r), .y_in(y_r), .q_in(qrd_r),
    .done(mdone), .result(mres)
  );

  // quotient stack; read at the next top so the popped entry is ready in ST_RD
  always_ff @(posedge clk) begin
    if (push) begin
      qmem[sp_r[SAW-2:0]] <= dq;
    end
    qrd_r <= qmem[sp_nxt[SAW-2:0]];
  end

  assign ra = in_tdata[W-1:0];
  assign rb = in_tdata[2*W-1:W];
  assign ma = ra[W-1] ? (~ra + 1'b1) : ra;
  assign mb = rb[W-1] ? (~rb + 1'b1) : rb;
  assign ca = swap_r ? y_r : x_r;
  assign cb = swap_r ? x_r : y_r;
  assign in_tready = (st_r == ST_IDLE) && !ov_r;

  // accept a pair, sequence forward division rounds, unwind the stack, emit the result
  always_comb begin
    st_nxt   = st_r;
    u_nxt    = u_r;
    v_nxt    = v_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    swap_nxt = swap_r;
    na_nxt   = na_r;
    nb_nxt   = nb_r;
    sp_nxt   = sp_r;
    ov_nxt   = ov_r;
    od_nxt   = od_r;
    ou_nxt   = ou_r;
    div_go   = 1'b0;
    mac_go   = 1'b0;
    push     = 1'b0;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (ma == '0 || mb == '0) begin
            od_nxt = '0;
            ou_nxt = 1'b1;
            ov_nxt = 1'b1;
          end else begin
            na_nxt   = ra[W-1];
            nb_nxt   = rb[W-1];
            swap_nxt = mb < ma;
            u_nxt    = (mb < ma) ? mb : ma;
            v_nxt    = (mb < ma) ? ma : mb;
            sp_nxt   = '0;
            st_nxt   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        div_go = 1'b1;
        st_nxt = ST_DWT;
      end
      ST_DWT: begin
        if (dctl.done) begin
          if (dr == '0) begin
            x_nxt  = (W+1)'(1);
            y_nxt  = '0;
            st_nxt = ST_POP;
          end else begin
            push   = (sp_r < SAW'(SD));
            sp_nxt = (sp_r < SAW'(SD)) ? sp_r + 1'b1 : sp_r;
            v_nxt  = u_r;
            u_nxt  = dr;
            st_nxt = ST_DIV;
          end
        end
      end
      ST_POP: begin
        if (sp_r == '0) begin
          st_nxt = ST_FIN;
        end else begin
          sp_nxt = sp_r - 1'b1;
          st_nxt = ST_RD;
        end
      end
      ST_RD: begin
        mac_go = 1'b1;
        st_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (mdone) begin
          y_nxt  = x_r;
          x_nxt  = mres;
          st_nxt = ST_POP;
        end
      end
      ST_FIN: begin
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r) begin
          od_nxt = OW'({nb_r ? -cb : cb, na_r ? -ca : ca, u_r});
          ou_nxt = 1'b0;
          ov_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      sp_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      sp_r <= sp_nxt;
    end
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    swap_r <= swap_nxt;
    na_r   <= na_nxt;
    nb_r   <= nb_nxt;
    od_r   <= od_nxt;
    ou_r   <= ou_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  // fill bits of the input word carry nothing
  if (IW > 2*W) begin : g_pad
    logic unused_pad;
    assign unused_pad = ^in_tdata[IW-1:2*W];
  end

  // checks on sequencing
  a_div_mac_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(dctl.busy && mdone)) else $error("divider and update overlap");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> st_r == ST_IDLE) else $error("ready outside idle");
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tdata == '0) else $error("undefined not zero");

endmodule

// ----- tb/sv/tb_extended_gcd_bezout.sv -----
// ============================================================================
// tb_extended_gcd_bezout: self-checking bench for the extended gcd block
// Drives operand pairs with random gaps. A scoreboard class predicts the gcd
// and Bezout coefficients of each accepted word and checks every result word
// in order. The result side applies random backpressure outside calm stretches.
// ============================================================================
module tb_extended_gcd_bezout;
  import egcd_pkg::*;

  localparam int W     = DATA_WIDTH_DEF;
  localparam int IW    = (2*W+7)/8*8;
  localparam int OW    = (3*W+2+7)/8*8;
  localparam int LIMIT = 8000000;

  typedef struct {
    logic [W-1:0] divisor;
    logic [W:0]   coef_a;
    logic [W:0]   coef_b;
    logic         undef;
  } gcd_result_t;

  // Predicts gcd results and checks them against the block's outputs
  class gcd_scoreboard;
    gcd_result_t pending_q[$];
    int errors;

    task report(string what, logic [W:0] got, logic [W:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    // Note an accepted operand pair and queue its expected result
    function void note(logic [W-1:0] a, logic [W-1:0] b);
      longint unsigned m, ma, mb, u, v, q, r, x, y, nx, ca, cb;
      longint unsigned quot_q[$];
      bit neg_a, neg_b, swap;
      gcd_result_t res;
      m = (64'd2 << (W-1)) - 1;
      neg_a = a[W-1];
      neg_b = b[W-1];
      ma = neg_a ? ((~longint'(a) + 1) & m) : longint'(a);
      mb = neg_b ? ((~longint'(b) + 1) & m) : longint'(b);
      if (ma == 0 || mb == 0) begin
        res = '{divisor: '0, coef_a: '0, coef_b: '0, undef: 1'b1};
        pending_q.push_back(res);
        return;
      end
      swap = mb < ma;
      u = swap ? mb : ma;
      v = swap ? ma : mb;
      // forward pass: keep quotients until the remainder vanishes
      forever begin
        q = v / u;
        r = v - q * u;
        if (r == 0) break;
        quot_q.push_back(q);
        v = u;
        u = r;
      end
      // backward pass: rebuild coefficients level by level
      x = 1;
      y = 0;
      while (quot_q.size() > 0) begin
        q = quot_q.pop_back();
        nx = y - x * q;
        y = x;
        x = nx;
      end
      ca = swap ? y : x;
      cb = swap ? x : y;
      if (neg_a) ca = 0 - ca;
      if (neg_b) cb = 0 - cb;
      res.divisor = u[W-1:0];
      res.coef_a  = ca[W:0];
      res.coef_b  = cb[W:0];
      res.undef   = 1'b0;
      pending_q.push_back(res);
    endfunction

    // Check one result word against the oldest expectation
    task check(logic [OW-1:0] data, logic user);
      gcd_result_t want;
      if (pending_q.size() == 0) begin
        report("unexpected word", data[W:0], '0);
        return;
      end
      want = pending_q.pop_front();
      if (data[W-1:0] !== want.divisor) report("divisor", data[W-1:0], want.divisor);
      if (data[2*W:W] !== want.coef_a) report("coef_a", data[2*W:W], want.coef_a);
      if (data[3*W+1:2*W+1] !== want.coef_b)
        report("coef_b", data[3*W+1:2*W+1], want.coef_b);
      if (user !== want.undef) report("undefined", user, want.undef);
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [IW-1:0] in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [OW-1:0] out_tdata;
  logic          out_tuser;

  gcd_scoreboard sb = new();
  int  cycles = 0;
  bit  calm = 1'b0;

  extended_gcd_bezout #(.DATA_WIDTH(W)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gap length: mostly short, a few long, none in calm stretches
  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 150);
  endfunction

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[extended_gcd_bezout] ERROR");
      $finish;
    end
  end

  // Random backpressure on the result side
  initial begin : ready_gen
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Check accepted result words
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tuser);
  end

  // Send one operand pair and wait for its acceptance
  task automatic send_pair(logic [W-1:0] a, logic [W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tdata  = '0;
    in_tdata[W-1:0]   = a;
    in_tdata[2*W-1:W] = b;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note(a, b);
  endtask

  // Random operand with random magnitude width and sign, now and then the most negative value or zero
  function automatic logic [W-1:0] rand_operand();
    logic [W-1:0] val;
    int bits;
    if ($urandom_range(0, 40) == 0) return {1'b1, {(W-1){1'b0}}};
    if ($urandom_range(0, 40) == 0) return '0;
    bits = $urandom_range(1, W);
    val = $urandom();
    val = val >> (W - bits);
    if ($urandom_range(0, 1)) val = -val;
    return val;
  endfunction

  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

  initial begin : main
    logic [W-1:0] a, b;
    int t;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: zeros, extremes, equal magnitudes, worst-case chain
    send_pair(0, 0);
    send_pair(0, 17);
    send_pair(-5, 0);
    send_pair(MINV, 0);
    send_pair(MINV, MINV);
    send_pair(MINV, MAXV);
    send_pair(MAXV, MINV);
    send_pair(MAXV, MAXV);
    send_pair(MINV, -1);
    send_pair(1, 1);
    send_pair(-1, -1);
    send_pair(12, -12);
    send_pair(-7, 7);
    send_pair(240, 46);
    send_pair(-46, 240);
    send_pair(32'd1836311903, 32'd1134903170);
    send_pair(-32'sd1134903170, -32'sd1836311903);
    send_pair(MINV, 32'd6);
    send_pair(32'hFFFF_FFFF, 32'hAAAA_AAAA);
    send_pair(32'h5555_5555, 32'hFFFF_FFFE);

    // random pairs, with calm stretches now and then
    for (t = 0; t < 400; t++) begin
      if (t % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      a = rand_operand();
      b = ($urandom_range(0, 15) == 0) ? -a : rand_operand();
      send_pair(a, b);
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[extended_gcd_bezout] OK");
    end else begin
      $display("[extended_gcd_bezout] ERROR");
    end
    $finish;
  end
endmodule
